// ----- design/pcc_pkg.sv -----
// Shared types and constants of the clamped PID controller.
// Used by the interfaces, the controller, the datapath and the top level.
package pcc_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned PROD_W = 64;
    localparam int unsigned ACC_W  = 34;
    localparam int unsigned MAG_W  = 49;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        REG_GAIN_P     = 3'd0,
        REG_GAIN_I     = 3'd1,
        REG_GAIN_D     = 3'd2,
        REG_OUT_LOW    = 3'd3,
        REG_OUT_HIGH   = 3'd4,
        REG_INTEG_LOW  = 3'd5,
        REG_INTEG_HIGH = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        MUL_ERR_DT,
        MUL_P,
        MUL_I,
        MUL_D
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD
    } t_acc_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ERR,
        ST_MUL_EDT,
        ST_INTEG,
        ST_ACC_P,
        ST_ACC_I,
        ST_DWAIT,
        ST_MUL_D,
        ST_ACC_D,
        ST_FINISH,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic signed [DATA_W-1:0] gain_p;
        logic signed [DATA_W-1:0] gain_i;
        logic signed [DATA_W-1:0] gain_d;
        logic signed [DATA_W-1:0] out_low;
        logic signed [DATA_W-1:0] out_high;
        logic signed [DATA_W-1:0] integ_low;
        logic signed [DATA_W-1:0] integ_high;
    } t_cfg;

    typedef struct packed {
        logic     load;
        logic     clear;
        logic     hold;
        logic     err_en;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     div_start;
        logic     integ_en;
        t_acc_op  acc_op;
        logic     deriv_en;
        logic     finish;
        logic     push;
    } t_dp_cmd;

    typedef struct packed {
        logic restart;
        logic dt_nonpos;
        logic div_busy;
    } t_dp_stat;

endpackage

// ----- design/pcc_if.sv -----
// Handshake channels of the clamped PID controller: input items and results.
// Depends on pcc_pkg for the field widths.
interface pcc_in_if;
    logic                                valid;
    logic                                ready;
    logic                                restart;
    logic signed [pcc_pkg::DATA_W-1:0]   target;
    logic signed [pcc_pkg::DATA_W-1:0]   measured;
    logic signed [pcc_pkg::DATA_W-1:0]   step_time;

    modport source (output valid, restart, target, measured, step_time, input ready);
    modport sink (input valid, restart, target, measured, step_time, output ready);
endinterface

interface pcc_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [pcc_pkg::DATA_W-1:0]   drive;

    modport source (output valid, drive, input ready);
    modport sink (input valid, drive, output ready);
endinterface

// ----- design/pid_controller_clamped_unit.sv -----
// An item with a positive time step is worked as follows from its accepting edge until
// its result is in the output register. The beat is decoded, the error is formed, and
// the divider is started together with the error-times-step product. The restoring
// divider that forms the derivative follows, and the integral clamp and the
// proportional and integral terms are worked while it runs. Then the quotient is taken,
// the derivative product is formed and added, and the output is clamped and handed over.
// When the derivative quotient already overflows at the start, the divider is skipped.
// A restart item or one with a time step at most zero goes from the decode step straight
// to the hand-over. One item is worked on at a time. The next beat is accepted at the
// edge after the previous result enters the output register, even if that result has
// not yet been taken. A result that is not taken stalls the next hand-over. All four
// products share one 32x32 multiplier. Configuration registers are to be written by the
// user through the APB port only while idle; the block itself does not enforce it.
module pid_controller_clamped_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    pcc_in_if.sink                            i_item,
    pcc_out_if.source                         o_result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pcc_pkg::ADDR_W-1:0]        paddr,
    input  logic [pcc_pkg::DATA_W-1:0]        pwdata,
    output logic [pcc_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    pcc_pkg::t_cfg      r_cfg;
    pcc_pkg::t_dp_cmd   cmd;
    pcc_pkg::t_dp_stat  stat;
    pcc_pkg::t_reg_idx  reg_idx;
    logic               wr_en;

    assign pready  = 1'b1;
    assign reg_idx = pcc_pkg::t_reg_idx'(paddr[pcc_pkg::ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p     <= '0;
            r_cfg.gain_i     <= '0;
            r_cfg.gain_d     <= '0;
            r_cfg.out_low    <= pcc_pkg::S32_MIN;
            r_cfg.out_high   <= pcc_pkg::S32_MAX;
            r_cfg.integ_low  <= pcc_pkg::S32_MIN;
            r_cfg.integ_high <= pcc_pkg::S32_MAX;
        end else if (wr_en) begin
            unique case (reg_idx)
                pcc_pkg::REG_GAIN_P:     r_cfg.gain_p     <= pwdata;
                pcc_pkg::REG_GAIN_I:     r_cfg.gain_i     <= pwdata;
                pcc_pkg::REG_GAIN_D:     r_cfg.gain_d     <= pwdata;
                pcc_pkg::REG_OUT_LOW:    r_cfg.out_low    <= pwdata;
                pcc_pkg::REG_OUT_HIGH:   r_cfg.out_high   <= pwdata;
                pcc_pkg::REG_INTEG_LOW:  r_cfg.integ_low  <= pwdata;
                pcc_pkg::REG_INTEG_HIGH: r_cfg.integ_high <= pwdata;
                default:                 r_cfg            <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            pcc_pkg::REG_GAIN_P:     prdata = r_cfg.gain_p;
            pcc_pkg::REG_GAIN_I:     prdata = r_cfg.gain_i;
            pcc_pkg::REG_GAIN_D:     prdata = r_cfg.gain_d;
            pcc_pkg::REG_OUT_LOW:    prdata = r_cfg.out_low;
            pcc_pkg::REG_OUT_HIGH:   prdata = r_cfg.out_high;
            pcc_pkg::REG_INTEG_LOW:  prdata = r_cfg.integ_low;
            pcc_pkg::REG_INTEG_HIGH: prdata = r_cfg.integ_high;
            default:                 prdata = '0;
        endcase
    end

    pcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    pcc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg       (r_cfg),
        .i_restart   (i_item.restart),
        .i_target    (i_item.target),
        .i_measured  (i_item.measured),
        .i_step_time (i_item.step_time),
        .o_drive     (o_result.drive)
    );

endmodule

// ----- design/pcc_div.sv -----
// Restoring divider, one quotient bit per cycle, for the derivative term.
// Produces the saturated signed 32-bit quotient. Depends on pcc_pkg.
module pcc_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic                               i_neg,
    input  logic [pcc_pkg::MAG_W-1:0]          i_mag,
    input  logic [pcc_pkg::DATA_W-2:0]         i_dvsr,
    output logic                               o_busy,
    output logic signed [pcc_pkg::DATA_W-1:0]  o_quot
);

    logic                           r_busy;
    logic [4:0]                     r_cnt;
    logic [pcc_pkg::DATA_W-2:0]     r_rem;
    logic [pcc_pkg::DATA_W-1:0]     r_q;
    logic                           r_ovf;
    logic                           r_neg;

    logic [pcc_pkg::DATA_W-1:0]     trial;
    logic [pcc_pkg::DATA_W-1:0]     diff;
    logic                           fits;
    logic                           start_ovf;

    assign start_ovf = {14'b0, i_mag[pcc_pkg::MAG_W-1:pcc_pkg::DATA_W]} >= i_dvsr;
    assign trial     = {r_rem, r_q[pcc_pkg::DATA_W-1]};
    assign fits      = trial >= {1'b0, i_dvsr};
    assign diff      = trial - {1'b0, i_dvsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= !start_ovf;
            r_cnt  <= 5'd31;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ovf <= start_ovf;
            r_neg <= i_neg;
            r_rem <= {14'b0, i_mag[pcc_pkg::MAG_W-1:pcc_pkg::DATA_W]};
            r_q   <= i_mag[pcc_pkg::DATA_W-1:0];
        end else if (r_busy) begin
            r_rem <= fits ? diff[pcc_pkg::DATA_W-2:0] : trial[pcc_pkg::DATA_W-2:0];
            r_q   <= {r_q[pcc_pkg::DATA_W-2:0], fits};
        end
    end

    always_comb begin
        if (r_neg) begin
            if (r_ovf || r_q > 32'h8000_0000) begin
                o_quot = pcc_pkg::S32_MIN;
            end else begin
                o_quot = -$signed(r_q);
            end
        end else begin
            if (r_ovf || r_q[pcc_pkg::DATA_W-1]) begin
                o_quot = pcc_pkg::S32_MAX;
            end else begin
                o_quot = $signed(r_q);
            end
        end
    end

    assign o_busy = r_busy;

endmodule

// ----- design/pcc_dp.sv -----
// Datapath of the clamped PID controller: shared multiplier, clamps, state.
// Depends on pcc_pkg and instantiates pcc_div.
module pcc_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pcc_pkg::t_dp_cmd                   i_cmd,
    output pcc_pkg::t_dp_stat                  o_stat,
    input  pcc_pkg::t_cfg                      i_cfg,
    input  logic                               i_restart,
    input  logic signed [pcc_pkg::DATA_W-1:0]  i_target,
    input  logic signed [pcc_pkg::DATA_W-1:0]  i_measured,
    input  logic signed [pcc_pkg::DATA_W-1:0]  i_step_time,
    output logic signed [pcc_pkg::DATA_W-1:0]  o_drive
);

    function automatic logic signed [31:0] clamp33(
        input logic signed [32:0] v,
        input logic signed [31:0] lo,
        input logic signed [31:0] hi
    );
        logic signed [31:0] r;
        if (v > 33'(hi)) begin
            r = hi;
        end else if (v < 33'(lo)) begin
            r = lo;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp34(
        input logic signed [33:0] v,
        input logic signed [31:0] lo,
        input logic signed [31:0] hi
    );
        logic signed [31:0] r;
        if (v > 34'(hi)) begin
            r = hi;
        end else if (v < 34'(lo)) begin
            r = lo;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic                                r_restart;
    logic signed [pcc_pkg::DATA_W-1:0]   r_target;
    logic signed [pcc_pkg::DATA_W-1:0]   r_measured;
    logic signed [pcc_pkg::DATA_W-1:0]   r_dt;
    logic signed [pcc_pkg::DATA_W-1:0]   r_err;
    logic signed [pcc_pkg::PROD_W-1:0]   r_prod;
    logic signed [pcc_pkg::DATA_W-1:0]   r_integ;
    logic signed [pcc_pkg::ACC_W-1:0]    r_acc;
    logic signed [pcc_pkg::DATA_W-1:0]   r_deriv;
    logic signed [pcc_pkg::DATA_W-1:0]   r_res;
    logic signed [pcc_pkg::DATA_W-1:0]   r_out_drive;
    logic signed [pcc_pkg::DATA_W-1:0]   r_integ_acc;
    logic signed [pcc_pkg::DATA_W-1:0]   r_prev_err;
    logic signed [pcc_pkg::DATA_W-1:0]   r_last_drive;
    logic                                r_has_hist;

    logic signed [32:0]                  err_wide;
    logic signed [pcc_pkg::DATA_W-1:0]   err_sat;
    logic signed [32:0]                  dnum;
    logic [32:0]                         dmag;
    logic signed [pcc_pkg::DATA_W-1:0]   mul_a;
    logic signed [pcc_pkg::DATA_W-1:0]   mul_b;
    logic signed [47:0]                  prod_sh;
    logic signed [pcc_pkg::DATA_W-1:0]   prod_q;
    logic signed [pcc_pkg::DATA_W-1:0]   integ_pre;
    logic signed [32:0]                  integ_sum;
    logic signed [pcc_pkg::DATA_W-1:0]   quot;
    logic                                div_busy;

    assign err_wide = 33'(r_target) - 33'(r_measured);
    always_comb begin
        if (err_wide > 33'(pcc_pkg::S32_MAX)) begin
            err_sat = pcc_pkg::S32_MAX;
        end else if (err_wide < 33'(pcc_pkg::S32_MIN)) begin
            err_sat = pcc_pkg::S32_MIN;
        end else begin
            err_sat = err_wide[31:0];
        end
    end

    assign dnum = 33'(r_err) - 33'(r_prev_err);
    assign dmag = dnum[32] ? 33'(-dnum) : 33'(dnum);

    pcc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_neg   (dnum[32]),
        .i_mag   ({dmag, 16'b0}),
        .i_dvsr  (r_dt[pcc_pkg::DATA_W-2:0]),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    always_comb begin
        case (i_cmd.mul_sel)
            pcc_pkg::MUL_ERR_DT: begin
                mul_a = r_err;
                mul_b = r_dt;
            end
            pcc_pkg::MUL_P: begin
                mul_a = i_cfg.gain_p;
                mul_b = r_err;
            end
            pcc_pkg::MUL_I: begin
                mul_a = i_cfg.gain_i;
                mul_b = r_integ;
            end
            default: begin
                mul_a = i_cfg.gain_d;
                mul_b = r_deriv;
            end
        endcase
    end

    assign prod_sh = r_prod[pcc_pkg::PROD_W-1:16];
    always_comb begin
        if (!prod_sh[47] && (|prod_sh[46:31])) begin
            prod_q = pcc_pkg::S32_MAX;
        end else if (prod_sh[47] && !(&prod_sh[46:31])) begin
            prod_q = pcc_pkg::S32_MIN;
        end else begin
            prod_q = prod_sh[31:0];
        end
    end

    assign integ_pre = clamp33(33'(r_integ_acc), i_cfg.integ_low, i_cfg.integ_high);
    assign integ_sum = 33'(integ_pre) + 33'(prod_q);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_restart  <= i_restart;
            r_target   <= i_target;
            r_measured <= i_measured;
            r_dt       <= i_step_time;
        end
        if (i_cmd.err_en) begin
            r_err <= err_sat;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.integ_en) begin
            r_integ <= clamp33(integ_sum, i_cfg.integ_low, i_cfg.integ_high);
        end
        case (i_cmd.acc_op)
            pcc_pkg::ACC_LOAD: r_acc <= 34'(prod_q);
            pcc_pkg::ACC_ADD:  r_acc <= r_acc + 34'(prod_q);
            default:           r_acc <= r_acc;
        endcase
        if (i_cmd.deriv_en) begin
            r_deriv <= r_has_hist ? quot : '0;
        end
        if (i_cmd.clear) begin
            r_res <= '0;
        end else if (i_cmd.hold) begin
            r_res <= r_last_drive;
        end else if (i_cmd.finish) begin
            r_res <= clamp34(r_acc, i_cfg.out_low, i_cfg.out_high);
        end
        if (i_cmd.push) begin
            r_out_drive <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_integ_acc  <= '0;
            r_prev_err   <= '0;
            r_last_drive <= '0;
            r_has_hist   <= 1'b0;
        end else if (i_cmd.finish) begin
            r_integ_acc  <= r_integ;
            r_prev_err   <= r_err;
            r_last_drive <= clamp34(r_acc, i_cfg.out_low, i_cfg.out_high);
            r_has_hist   <= 1'b1;
        end
    end

    assign o_stat.restart   = r_restart;
    assign o_stat.dt_nonpos = r_dt[pcc_pkg::DATA_W-1] || (r_dt == '0);
    assign o_stat.div_busy  = div_busy;
    assign o_drive          = r_out_drive;

endmodule

// ----- design/pcc_ctrl.sv -----
// Sequencer of the clamped PID controller: steps the datapath through one item.
// Also owns the valid flag of the result register. Depends on pcc_pkg.
module pcc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pcc_pkg::t_dp_cmd   o_cmd,
    input  pcc_pkg::t_dp_stat  i_stat
);

    pcc_pkg::t_state r_state;
    pcc_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pcc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pcc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = pcc_pkg::ST_DECODE;
                end
            end
            pcc_pkg::ST_DECODE: begin
                if (i_stat.restart || i_stat.dt_nonpos) begin
                    n_state = pcc_pkg::ST_PUSH;
                end else begin
                    n_state = pcc_pkg::ST_ERR;
                end
            end
            pcc_pkg::ST_ERR:     n_state = pcc_pkg::ST_MUL_EDT;
            pcc_pkg::ST_MUL_EDT: n_state = pcc_pkg::ST_INTEG;
            pcc_pkg::ST_INTEG:   n_state = pcc_pkg::ST_ACC_P;
            pcc_pkg::ST_ACC_P:   n_state = pcc_pkg::ST_ACC_I;
            pcc_pkg::ST_ACC_I:   n_state = pcc_pkg::ST_DWAIT;
            pcc_pkg::ST_DWAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = pcc_pkg::ST_MUL_D;
                end
            end
            pcc_pkg::ST_MUL_D:   n_state = pcc_pkg::ST_ACC_D;
            pcc_pkg::ST_ACC_D:   n_state = pcc_pkg::ST_FINISH;
            pcc_pkg::ST_FINISH:  n_state = pcc_pkg::ST_PUSH;
            pcc_pkg::ST_PUSH: begin
                if (out_free) begin
                    n_state = pcc_pkg::ST_IDLE;
                end
            end
            default:             n_state = pcc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = pcc_pkg::MUL_ERR_DT;
        o_cmd.acc_op  = pcc_pkg::ACC_NONE;
        o_in_ready    = 1'b0;
        unique case (r_state)
            pcc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            pcc_pkg::ST_DECODE: begin
                o_cmd.clear = i_stat.restart;
                o_cmd.hold  = !i_stat.restart && i_stat.dt_nonpos;
            end
            pcc_pkg::ST_ERR: begin
                o_cmd.err_en = 1'b1;
            end
            pcc_pkg::ST_MUL_EDT: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_sel   = pcc_pkg::MUL_ERR_DT;
                o_cmd.div_start = 1'b1;
            end
            pcc_pkg::ST_INTEG: begin
                o_cmd.integ_en = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = pcc_pkg::MUL_P;
            end
            pcc_pkg::ST_ACC_P: begin
                o_cmd.acc_op  = pcc_pkg::ACC_LOAD;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = pcc_pkg::MUL_I;
            end
            pcc_pkg::ST_ACC_I: begin
                o_cmd.acc_op = pcc_pkg::ACC_ADD;
            end
            pcc_pkg::ST_DWAIT: begin
                o_cmd.deriv_en = !i_stat.div_busy;
            end
            pcc_pkg::ST_MUL_D: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = pcc_pkg::MUL_D;
            end
            pcc_pkg::ST_ACC_D: begin
                o_cmd.acc_op = pcc_pkg::ACC_ADD;
            end
            pcc_pkg::ST_FINISH: begin
                o_cmd.finish = 1'b1;
            end
            pcc_pkg::ST_PUSH: begin
                o_cmd.push = out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.push) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while still holding a beat");

    a_div_idle_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_stat.div_busy)
        else $error("divider started while busy");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == pcc_pkg::ST_DECODE))
        else $error("accepted beat not decoded next cycle");

    a_deriv_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pcc_pkg::ST_MUL_D) |-> !i_stat.div_busy)
        else $error("derivative used before the divider finished");

endmodule

// ----- tb/tb_pid_controller_clamped_unit.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the clamped PID controller: a directed table, then randomized
// phases under changing gains and clamps, each result beat checked against a typed value or a Q16.16 predictor.
// Depends on pcc_pkg, the pcc_in_if and pcc_out_if interfaces and the design top level.
module tb_pid_controller_clamped_unit;

    localparam int unsigned       CLK_HALF     = 6;
    localparam int unsigned       RESET_CYCLES = 7;
    localparam int unsigned       SETTLE       = 45;
    localparam int unsigned       TAIL_CYCLES  = 60;
    localparam int unsigned       LONG_HOLD    = 300;
    localparam int unsigned       NUM_PHASES   = 8;
    localparam int unsigned       PHASE_ITEMS  = 136;
    localparam int unsigned       MAX_CYCLES   = 500_000;
    localparam int unsigned       SHOW_LIMIT   = 10;
    localparam int unsigned       NUM_REGS     = 7;
    localparam logic [2:0]        REG_NONE     = 3'd7;
    localparam logic [pcc_pkg::DATA_W-1:0] Q_ONE = 32'h0001_0000;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind                  kind;
        logic [2:0]                 idx;
        logic                       restart;
        logic [pcc_pkg::DATA_W-1:0] target;
        logic [pcc_pkg::DATA_W-1:0] measured;
        logic [pcc_pkg::DATA_W-1:0] step_time;
        logic                       known;
        logic [pcc_pkg::DATA_W-1:0] drive;
    } t_row;

    typedef struct {
        int unsigned                seq;
        logic [pcc_pkg::DATA_W-1:0] drive;
    } t_drive_exp;

    // Register rows carry the write data in the target column. Item rows with the known bit set
    // check the typed drive; all other item rows check the predictor.
    localparam t_row DIRECTED [25] = '{
        '{ROW_ITEM, '0, 1'b0, Q_ONE, 32'h0, Q_ONE, 1'b1, 32'h0},
        '{ROW_CFG, pcc_pkg::REG_GAIN_P, 1'b0, Q_ONE, 32'h0, 32'h0, 1'b0, 32'h0},
        '{ROW_CFG, pcc_pkg::REG_GAIN_I, 1'b0, Q_ONE, 32'h0, 32'h0, 1'b0, 32'h0},
        '{ROW_CFG, pcc_pkg::REG_GAIN_D, 1'b0, Q_ONE, 32'h0, 32'h0, 1'b0, 32'h0},
        '{ROW_ITEM, '0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0},
        '{ROW_ITEM, '0, 1'b0, pcc_pkg::S32_MAX, pcc_pkg::S32_MIN, Q_ONE, 1'b1,
          pcc_pkg::S32_MAX},
        '{ROW_ITEM, '0, 1'b0, pcc_pkg::S32_MIN, pcc_pkg::S32_MAX, Q_ONE, 1'b1,
          pcc_pkg::S32_MIN},
        '{ROW_ITEM, '0, 1'b0, 32'h0123_4567, 32'h7654_3210, 32'h0, 1'b1, pcc_pkg::S32_MIN},
        '{ROW_ITEM, '0, 1'b0, 32'h0, 32'h0, pcc_pkg::S32_MIN, 1'b1, pcc_pkg::S32_MIN},
        '{ROW_ITEM, '0, 1'b1, pcc_pkg::S32_MAX, pcc_pkg::S32_MIN, Q_ONE, 1'b1, 32'h0},
        '{ROW_ITEM, '0, 1'b0, 32'h0003_0000, 32'h0001_0000, Q_ONE, 1'b1, 32'h0004_0000},
        '{ROW_ITEM, '0, 1'b0, 32'h0003_0000, 32'h0001_0000, 32'h0000_8000, 1'b0, 32'h0},
        '{ROW_ITEM, '0, 1'b0, 32'h0000_0005, 32'hFFFF_FFFD, 32'h0000_0001, 1'b0, 32'h0},
        '{ROW_ITEM, '0, 1'b0, 32'hFFFF_FFFF, 32'h0, pcc_pkg::S32_MAX, 1'b0, 32'h0},
        '{ROW_ITEM, '0, 1'b0, pcc_pkg::S32_MIN, pcc_pkg::S32_MIN, Q_ONE, 1'b0, 32'h0},
        '{ROW_CFG, pcc_pkg::REG_OUT_LOW, 1'b0, 32'h0005_0000, 32'h0, 32'h0, 1'b0, 32'h0},
        '{ROW_CFG, pcc_pkg::REG_OUT_HIGH, 1'b0, 32'h0001_0000, 32'h0, 32'h0, 1'b0, 32'h0},
        '{ROW_CFG, pcc_pkg::REG_INTEG_LOW, 1'b0, 32'hFFFF_8000, 32'h0, 32'h0, 1'b0, 32'h0},
        '{ROW_CFG, pcc_pkg::REG_INTEG_HIGH, 1'b0, 32'h0000_8000, 32'h0, 32'h0, 1'b0, 32'h0},
        '{ROW_CFG, REG_NONE, 1'b0, 32'hDEAD_BEEF, 32'h0, 32'h0, 1'b0, 32'h0},
        '{ROW_ITEM, '0, 1'b0, 32'h0010_0000, 32'h0, Q_ONE, 1'b0, 32'h0},
        '{ROW_ITEM, '0, 1'b0, 32'hFFF0_0000, 32'h0, Q_ONE, 1'b0, 32'h0},
        '{ROW_ITEM, '0, 1'b0, 32'h0000_4000, 32'h0, Q_ONE, 1'b0, 32'h0},
        '{ROW_ITEM, '0, 1'b1, 32'h0, 32'h0, 32'h0, 1'b1, 32'h0},
        '{ROW_ITEM, '0, 1'b0, Q_ONE, 32'h0, 32'hFFFF_FFFF, 1'b1, 32'h0}
    };

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [pcc_pkg::ADDR_W-1:0] paddr;
    logic [pcc_pkg::DATA_W-1:0] pwdata;
    logic [pcc_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    pcc_in_if  item_ch ();
    pcc_out_if result_ch ();

    pid_controller_clamped_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    pcc_pkg::t_cfg cfg_shadow;
    longint        integ_state;
    longint        err_state;
    longint        drive_state;
    bit            primed;
    t_drive_exp    drive_q[$];
    int unsigned   mismatch_count = 0;
    int unsigned   n_items = 0;
    int unsigned   n_restart = 0;
    int unsigned   n_held = 0;
    int unsigned   n_checked = 0;
    int unsigned   n_writes = 0;
    int unsigned   cycle_count = 0;
    bit            quiet = 1'b0;
    bit            long_hold_req = 1'b0;

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic void flag_error(input string what,
                                       input logic [pcc_pkg::DATA_W-1:0] exp_v,
                                       input logic [pcc_pkg::DATA_W-1:0] got_v);
        mismatch_count++;
        if (mismatch_count <= SHOW_LIMIT)
            $display("%0t %s: expected %h, got %h", $time, what, exp_v, got_v);
    endfunction

    function automatic longint sat32(input longint v);
        if (v > longint'(pcc_pkg::S32_MAX)) return longint'(pcc_pkg::S32_MAX);
        if (v < longint'(pcc_pkg::S32_MIN)) return longint'(pcc_pkg::S32_MIN);
        return v;
    endfunction

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Q16.16 product, floored back to Q16.16 and saturated.
    function automatic longint q_mul(input longint a, input longint b);
        return sat32((a * b) >>> 16);
    endfunction

    function automatic logic [pcc_pkg::DATA_W-1:0] predict_drive(input logic restart,
            input logic signed [pcc_pkg::DATA_W-1:0] tgt, meas, dt);
        longint err;
        longint rate;
        longint integ;
        longint sum;
        if (restart) begin
            integ_state = 0;
            err_state   = 0;
            drive_state = 0;
            primed      = 1'b0;
            return '0;
        end
        if (dt <= 0) return drive_state[pcc_pkg::DATA_W-1:0];
        err   = sat32(longint'(tgt) - longint'(meas));
        rate  = primed ? sat32(((err - err_state) * 65536) / longint'(dt)) : 0;
        integ = clamp_to(integ_state, cfg_shadow.integ_low, cfg_shadow.integ_high);
        integ = clamp_to(integ + q_mul(err, dt), cfg_shadow.integ_low, cfg_shadow.integ_high);
        sum   = q_mul(cfg_shadow.gain_p, err) + q_mul(cfg_shadow.gain_i, integ)
              + q_mul(cfg_shadow.gain_d, rate);
        sum   = clamp_to(sum, cfg_shadow.out_low, cfg_shadow.out_high);
        integ_state = integ;
        err_state   = err;
        drive_state = sum;
        primed      = 1'b1;
        return sum[pcc_pkg::DATA_W-1:0];
    endfunction

    function automatic void shadow_write(input int unsigned idx,
                                         input logic [pcc_pkg::DATA_W-1:0] v);
        case (idx)
            pcc_pkg::REG_GAIN_P:     cfg_shadow.gain_p = v;
            pcc_pkg::REG_GAIN_I:     cfg_shadow.gain_i = v;
            pcc_pkg::REG_GAIN_D:     cfg_shadow.gain_d = v;
            pcc_pkg::REG_OUT_LOW:    cfg_shadow.out_low = v;
            pcc_pkg::REG_OUT_HIGH:   cfg_shadow.out_high = v;
            pcc_pkg::REG_INTEG_LOW:  cfg_shadow.integ_low = v;
            pcc_pkg::REG_INTEG_HIGH: cfg_shadow.integ_high = v;
            default: ;
        endcase
    endfunction

    function automatic logic [pcc_pkg::DATA_W-1:0] reg_value(input int unsigned idx);
        case (idx)
            pcc_pkg::REG_GAIN_P:    return cfg_shadow.gain_p;
            pcc_pkg::REG_GAIN_I:    return cfg_shadow.gain_i;
            pcc_pkg::REG_GAIN_D:    return cfg_shadow.gain_d;
            pcc_pkg::REG_OUT_LOW:   return cfg_shadow.out_low;
            pcc_pkg::REG_OUT_HIGH:  return cfg_shadow.out_high;
            pcc_pkg::REG_INTEG_LOW: return cfg_shadow.integ_low;
            default:                return cfg_shadow.integ_high;
        endcase
    endfunction

    function automatic logic [pcc_pkg::DATA_W-1:0] pick_edge();
        case ($urandom_range(0, 4))
            0:       return pcc_pkg::S32_MIN;
            1:       return pcc_pkg::S32_MAX;
            2:       return '0;
            3:       return '1;
            default: return Q_ONE;
        endcase
    endfunction

    function automatic logic [pcc_pkg::DATA_W-1:0] rand_level();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return pick_edge();
            default: return pcc_pkg::DATA_W'($urandom_range(0, 32'h0007_FFFF)) - 32'h0004_0000;
        endcase
    endfunction

    function automatic logic [pcc_pkg::DATA_W-1:0] rand_step();
        logic [pcc_pkg::DATA_W-1:0] r;
        r = $urandom();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return {1'b1, r[pcc_pkg::DATA_W-2:0]};
            2:       return {1'b0, r[pcc_pkg::DATA_W-2:0]};
            3:       return pcc_pkg::DATA_W'($urandom_range(1, 16));
            4:       return Q_ONE;
            default: return pcc_pkg::DATA_W'($urandom_range(1, 32'h0004_0000));
        endcase
    endfunction

    function automatic logic [pcc_pkg::DATA_W-1:0] rand_gain();
        case ($urandom_range(0, 7))
            0:       return pcc_pkg::S32_MIN;
            1:       return pcc_pkg::S32_MAX;
            2:       return '0;
            3:       return Q_ONE;
            default: return pcc_pkg::DATA_W'($urandom_range(0, 32'h0003_FFFF)) - 32'h0002_0000;
        endcase
    endfunction

    function automatic void pick_limits(output logic [pcc_pkg::DATA_W-1:0] lo,
                                        output logic [pcc_pkg::DATA_W-1:0] hi);
        logic signed [pcc_pkg::DATA_W-1:0] a;
        logic signed [pcc_pkg::DATA_W-1:0] b;
        a = rand_level();
        b = rand_level();
        case ($urandom_range(0, 5))
            0: begin
                lo = pcc_pkg::S32_MIN;
                hi = pcc_pkg::S32_MAX;
            end
            1: begin
                lo = (a > b) ? a : b;
                hi = (a > b) ? b : a;
            end
            default: begin
                lo = (a > b) ? b : a;
                hi = (a > b) ? a : b;
            end
        endcase
    endfunction

    task automatic apb_access(input bit wr, input int unsigned idx,
                              input logic [pcc_pkg::DATA_W-1:0] wdata,
                              output logic [pcc_pkg::DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= pcc_pkg::ADDR_W'(idx * 4);
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_regs();
        logic [pcc_pkg::DATA_W-1:0] rd;
        for (int unsigned k = 0; k < NUM_REGS; k++) begin
            apb_access(1'b0, k, '0, rd);
            if (rd !== reg_value(k))
                flag_error($sformatf("register %0d read", k), reg_value(k), rd);
        end
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (drive_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input int unsigned idx, input logic [pcc_pkg::DATA_W-1:0] v);
        logic [pcc_pkg::DATA_W-1:0] ignored;
        wait_drained();
        apb_access(1'b1, idx, v, ignored);
        shadow_write(idx, v);
        n_writes++;
        check_regs();
    endtask

    task automatic send_item(input logic restart,
                             input logic signed [pcc_pkg::DATA_W-1:0] tgt, meas, dt,
                             input logic known, input logic [pcc_pkg::DATA_W-1:0] typed);
        logic [pcc_pkg::DATA_W-1:0] pred;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.restart   <= restart;
        item_ch.target    <= tgt;
        item_ch.measured  <= meas;
        item_ch.step_time <= dt;
        do @(posedge i_clk); while (!item_ch.ready);
        pred = predict_drive(restart, tgt, meas, dt);
        drive_q.push_back('{seq: n_items, drive: known ? typed : pred});
        n_items++;
        if (restart) n_restart++;
        else if (dt <= 0) n_held++;
    endtask

    task automatic set_phase_config(input int unsigned phase);
        logic [pcc_pkg::DATA_W-1:0] lo_d;
        logic [pcc_pkg::DATA_W-1:0] hi_d;
        logic [pcc_pkg::DATA_W-1:0] lo_i;
        logic [pcc_pkg::DATA_W-1:0] hi_i;
        pick_limits(lo_d, hi_d);
        pick_limits(lo_i, hi_i);
        if (phase == 0) begin
            write_reg(pcc_pkg::REG_GAIN_P, pcc_pkg::S32_MIN);
            write_reg(pcc_pkg::REG_GAIN_I, pcc_pkg::S32_MAX);
            write_reg(pcc_pkg::REG_GAIN_D, pcc_pkg::S32_MIN);
            lo_d = pcc_pkg::S32_MIN;
            hi_d = pcc_pkg::S32_MAX;
            lo_i = pcc_pkg::S32_MIN;
            hi_i = pcc_pkg::S32_MAX;
        end else if (phase == 1) begin
            write_reg(pcc_pkg::REG_GAIN_P, pcc_pkg::S32_MAX);
            write_reg(pcc_pkg::REG_GAIN_I, pcc_pkg::S32_MIN);
            write_reg(pcc_pkg::REG_GAIN_D, pcc_pkg::S32_MAX);
            lo_d = pcc_pkg::S32_MAX;
            hi_d = pcc_pkg::S32_MIN;
            lo_i = pcc_pkg::S32_MAX;
            hi_i = pcc_pkg::S32_MIN;
        end else begin
            write_reg(pcc_pkg::REG_GAIN_P, rand_gain());
            write_reg(pcc_pkg::REG_GAIN_I, rand_gain());
            write_reg(pcc_pkg::REG_GAIN_D, rand_gain());
        end
        write_reg(pcc_pkg::REG_OUT_LOW, lo_d);
        write_reg(pcc_pkg::REG_OUT_HIGH, hi_d);
        write_reg(pcc_pkg::REG_INTEG_LOW, lo_i);
        write_reg(pcc_pkg::REG_INTEG_HIGH, hi_i);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("Cycle limit reached with %0d results outstanding.", drive_q.size());
            $display("tb_pid_controller_clamped_unit: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_drive_exp exp_beat;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (drive_q.size() == 0) begin
                flag_error("unexpected result beat", 'x, result_ch.drive);
            end else begin
                exp_beat = drive_q.pop_front();
                n_checked++;
                if (result_ch.drive !== exp_beat.drive)
                    flag_error($sformatf("item %0d drive", exp_beat.seq), exp_beat.drive,
                               result_ch.drive);
            end
        end
    end

    initial begin : result_sink
        result_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                result_ch.ready <= 1'b0;
                for (int unsigned k = 0; k < LONG_HOLD; k++) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                result_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        t_row row;
        cfg_shadow = '{gain_p: '0, gain_i: '0, gain_d: '0,
                       out_low: pcc_pkg::S32_MIN, out_high: pcc_pkg::S32_MAX,
                       integ_low: pcc_pkg::S32_MIN, integ_high: pcc_pkg::S32_MAX};
        i_rst_n           <= 1'b0;
        item_ch.valid     <= 1'b0;
        item_ch.restart   <= 1'b0;
        item_ch.target    <= '0;
        item_ch.measured  <= '0;
        item_ch.step_time <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_regs();

        for (int k = 0; k < $size(DIRECTED); k++) begin
            row = DIRECTED[k];
            if (row.kind == ROW_CFG)
                write_reg(row.idx, row.target);
            else
                send_item(row.restart, row.target, row.measured, row.step_time, row.known,
                          row.drive);
        end

        for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
            quiet = (phase == NUM_PHASES - 1);
            set_phase_config(phase);
            for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 1 && n == 20)
                    long_hold_req = 1'b1;
                if (phase == 2 && n == PHASE_ITEMS / 2)
                    wait_drained();
                send_item($urandom_range(0, 29) == 0, rand_level(), rand_level(), rand_step(),
                          1'b0, '0);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Drove %0d items (%0d restarts, %0d held steps) across %0d register writes.",
                 n_items, n_restart, n_held, n_writes);
        $display("Checked %0d result beats; %0d mismatches, %0d results missing.",
                 n_checked, mismatch_count, drive_q.size());
        if (mismatch_count == 0 && drive_q.size() == 0)
            $display("tb_pid_controller_clamped_unit: clean");
        else
            $display("tb_pid_controller_clamped_unit: errors");
        $finish;
    end

endmodule
